// File: rtl/tecs_pkg.sv
// ----------------------------------------------------------------------------
// tecs_pkg
// Shared widths, codes and types of the table entry statistics collector.
// ----------------------------------------------------------------------------
package tecs_pkg;

  localparam int unsigned WindowDepth = 4096;

  localparam int unsigned IdW      = 32;
  localparam int unsigned KeyW     = 16;
  localparam int unsigned ValW     = 24;
  localparam int unsigned TypeW    = 3;
  localparam int unsigned SizeW    = 48;
  localparam int unsigned CountW   = 40;
  localparam int unsigned HalfW    = 20;
  localparam int unsigned WinW     = 13;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 48;

  localparam logic [KeyW-1:0] MinKeyLen = KeyW'(4);

  typedef enum logic [TypeW-1:0] {
    EtPut          = 3'd0,
    EtDelete       = 3'd1,
    EtSingleDelete = 3'd2,
    EtMerge        = 3'd3,
    EtOther        = 3'd4
  } entry_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWindowLen          = 8'd0,
    CfgDeleteThreshold    = 8'd1,
    CfgFileSizeThreshold  = 8'd2,
    CfgCountSingleDeletes = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [WinW-1:0]  window_len;
    logic [WinW-1:0]  delete_threshold;
    logic [SizeW-1:0] file_size_threshold;
    logic             count_single_deletes;
  } cfg_t;

  typedef struct packed {
    logic acc;
    logic en;
    logic is_del;
    logic go;
  } win_ctl_t;

  typedef struct packed {
    logic [WinW-1:0] count;
    logic [WinW-1:0] max;
  } win_stat_t;

endpackage

// File: rtl/tecs_if.sv
// ----------------------------------------------------------------------------
// tecs_if
// Valid/ready channels of the collector: entries in, results out, and the
// configuration write channel.
// ----------------------------------------------------------------------------
interface tecs_entry_if;
  logic                       valid;
  logic                       ready;
  logic [tecs_pkg::IdW-1:0]   key_index;
  logic [tecs_pkg::KeyW-1:0]  key_len;
  logic [tecs_pkg::ValW-1:0]  value_len;
  logic [tecs_pkg::TypeW-1:0] entry_type;
  logic [tecs_pkg::SizeW-1:0] file_bytes;

  modport source(output valid, key_index, key_len, value_len, entry_type, file_bytes,
                 input ready);
  modport sink(input valid, key_index, key_len, value_len, entry_type, file_bytes,
               output ready);
endinterface

interface tecs_result_if;
  logic                        valid;
  logic                        ready;
  logic                        ignored;
  logic                        bad_type;
  logic                        new_run;
  logic [tecs_pkg::CountW-1:0] run_puts;
  logic [tecs_pkg::CountW-1:0] run_deletes;
  logic [tecs_pkg::CountW-1:0] run_single_deletes;
  logic [tecs_pkg::CountW-1:0] run_merges_and_others;
  logic [tecs_pkg::SizeW-1:0]  run_data_bytes;
  logic [tecs_pkg::SizeW-1:0]  run_disk_bytes;
  logic [tecs_pkg::WinW-1:0]   window_deletes;
  logic [tecs_pkg::WinW-1:0]   max_window_deletes;
  logic                        need_compact;

  modport source(output valid, ignored, bad_type, new_run, run_puts, run_deletes,
                 run_single_deletes, run_merges_and_others, run_data_bytes,
                 run_disk_bytes, window_deletes, max_window_deletes, need_compact,
                 input ready);
  modport sink(input valid, ignored, bad_type, new_run, run_puts, run_deletes,
               run_single_deletes, run_merges_and_others, run_data_bytes,
               run_disk_bytes, window_deletes, max_window_deletes, need_compact,
               output ready);
endinterface

interface tecs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tecs_pkg::CfgIdxW-1:0]  index;
  logic [tecs_pkg::CfgDataW-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/tecs_ram.sv
// ----------------------------------------------------------------------------
// tecs_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module tecs_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4096
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tecs_cfg_regs.sv
// ----------------------------------------------------------------------------
// tecs_cfg_regs
// Configuration register bank; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module tecs_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  tecs_cfg_if.sink       cfg_i,
  output tecs_pkg::cfg_t cfg_o
);

  tecs_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        tecs_pkg::CfgWindowLen: begin
          cfg_d.window_len = cfg_i.data[tecs_pkg::WinW-1:0];
        end
        tecs_pkg::CfgDeleteThreshold: begin
          cfg_d.delete_threshold = cfg_i.data[tecs_pkg::WinW-1:0];
        end
        tecs_pkg::CfgFileSizeThreshold: begin
          cfg_d.file_size_threshold = cfg_i.data[tecs_pkg::SizeW-1:0];
        end
        tecs_pkg::CfgCountSingleDeletes: begin
          cfg_d.count_single_deletes = cfg_i.data[0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/tecs_window.sv
// ----------------------------------------------------------------------------
// tecs_window
// Delete-flag ring in RAM with read-modify-write over two stages, the live
// delete count, its maximum, and the clearing pass after reset.
// ----------------------------------------------------------------------------
module tecs_window #(
  parameter int unsigned WindowDepth = tecs_pkg::WindowDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tecs_pkg::cfg_t      cfg_i,
  input  tecs_pkg::win_ctl_t  ctl_i,
  output logic                busy_o,
  output tecs_pkg::win_stat_t stat_o
);

  localparam int unsigned AddrW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned LenW  = (AddrW + 1 > tecs_pkg::WinW) ? AddrW + 1 : tecs_pkg::WinW;

  logic [AddrW-1:0]         pos_q, pos_d;
  logic [AddrW-1:0]         pos_use, pos_nxt;
  logic [LenW-1:0]          len_ext, eff_len, pos_inc;
  logic                     win_on, rd_en;
  logic                     s1_en_q, s1_del_q;
  logic [AddrW-1:0]         s1_addr_q;
  logic                     fwd_q, fwd_flag_q;
  logic                     s1_we, flag;
  logic                     rdata;
  logic                     clr_q;
  logic [AddrW-1:0]         clr_addr_q;
  logic                     ram_we, ram_wdata;
  logic [AddrW-1:0]         ram_waddr;
  logic [tecs_pkg::WinW-1:0] count_q, count_d, max_q, max_d;

  assign win_on  = (cfg_i.window_len != '0);
  assign len_ext = LenW'(cfg_i.window_len);
  assign eff_len = (len_ext > LenW'(WindowDepth)) ? LenW'(WindowDepth) : len_ext;
  assign pos_use = (LenW'(pos_q) >= eff_len) ? '0 : pos_q;
  assign pos_inc = LenW'(pos_use) + LenW'(1);
  assign pos_nxt = (pos_inc >= eff_len) ? '0 : pos_inc[AddrW-1:0];
  assign rd_en   = ctl_i.acc && ctl_i.en && win_on;
  assign pos_d   = rd_en ? pos_nxt : pos_q;

  assign s1_we = ctl_i.go && s1_en_q;
  assign flag  = fwd_q ? fwd_flag_q : rdata;

  always_comb begin
    count_d = count_q;
    max_d   = max_q;
    if (s1_we && (flag != s1_del_q)) begin
      if (s1_del_q) begin
        count_d = count_q + tecs_pkg::WinW'(1);
        if (count_d > max_q) begin
          max_d = count_d;
        end
      end else begin
        count_d = count_q - tecs_pkg::WinW'(1);
      end
    end
  end

  assign ram_we    = clr_q || s1_we;
  assign ram_waddr = clr_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_q ? 1'b0 : s1_del_q;

  tecs_ram #(
    .Width(1),
    .Depth(WindowDepth)
  ) u_flags (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (rd_en),
    .raddr_i(pos_use),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      count_q    <= '0;
      max_q      <= '0;
      s1_en_q    <= 1'b0;
      fwd_q      <= 1'b0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      pos_q   <= pos_d;
      count_q <= count_d;
      max_q   <= max_d;
      if (ctl_i.acc) begin
        s1_en_q <= ctl_i.en && win_on;
        fwd_q   <= s1_we && (s1_addr_q == pos_use);
      end
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
        if (clr_addr_q == AddrW'(WindowDepth - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc) begin
      s1_del_q   <= ctl_i.is_del;
      s1_addr_q  <= pos_use;
      fwd_flag_q <= s1_del_q;
    end
  end

  assign busy_o       = clr_q;
  assign stat_o.count = count_d;
  assign stat_o.max   = max_d;

endmodule

// File: rtl/table_entry_stats_collector.sv
// ----------------------------------------------------------------------------
// table_entry_stats_collector
// Per-entry statistics for a table writer: delete window and per-index runs.
// ----------------------------------------------------------------------------
// Entries arrive on entry_i and each produces exactly one result on
// result_o; cfg_i writes the four configuration registers. The user must
// make these writes only while the block is idle; the block itself does not
// enforce this. A transfer takes place when valid and ready are both high.
// An entry is accepted in a stage that issues the delete-flag RAM read; the
// next stage merges the read flag, writes it back and updates all counters,
// and the result register presents the outcome. The update stage moves on
// when the result register is free or being taken, and one entry per cycle
// is sustained while result_o.ready stays high; the single write port of
// the flag RAM sets this rate. Back-to-back entries that land on the same
// flag are served by forwarding. After reset the flag RAM is swept to zero,
// one entry per cycle; entry_i.ready stays low during the sweep while
// configuration writes are taken as usual. When result_o.ready is low, one
// finished result waits in the output register and one more entry waits in
// the update stage; then entry_i.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module table_entry_stats_collector #(
  parameter int unsigned WindowDepth = tecs_pkg::WindowDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tecs_cfg_if.sink       cfg_i,
  tecs_entry_if.sink     entry_i,
  tecs_result_if.source  result_o
);

  localparam int unsigned DsumW = tecs_pkg::ValW + 1;
  localparam int unsigned AddW  = tecs_pkg::SizeW + 1;

  function automatic logic [tecs_pkg::CountW-1:0] sat_cnt(
    input logic [tecs_pkg::CountW-1:0] v
  );
    return (&v) ? v : v + tecs_pkg::CountW'(1);
  endfunction

  function automatic logic [tecs_pkg::HalfW-1:0] sat_half(
    input logic [tecs_pkg::HalfW-1:0] v
  );
    return (&v) ? v : v + tecs_pkg::HalfW'(1);
  endfunction

  tecs_pkg::cfg_t      cfg;
  tecs_pkg::win_ctl_t  win_ctl;
  tecs_pkg::win_stat_t win_stat;
  logic                busy;

  logic                        acc, ign, fresh, is_del, bad;
  logic                        run_open_q;
  logic [tecs_pkg::IdW-1:0]    cur_idx_q;
  logic [tecs_pkg::SizeW-1:0]  last_fs_q;

  logic                        s1_valid_q, s1_go;
  logic                        s1_ign_q, s1_bad_q, s1_fresh_q;
  logic [tecs_pkg::TypeW-1:0]  s1_type_q;
  logic [DsumW-1:0]            s1_dsum_q;
  logic [tecs_pkg::SizeW-1:0]  s1_diff_q;

  logic [tecs_pkg::CountW-1:0] puts_q, puts_d, dels_q, dels_d;
  logic [tecs_pkg::CountW-1:0] sdels_q, sdels_d, mo_q, mo_d;
  logic [tecs_pkg::CountW-1:0] puts_b, dels_b, sdels_b, mo_b;
  logic [tecs_pkg::SizeW-1:0]  data_q, data_d, disk_q, disk_d, data_b, disk_b;
  logic [AddW-1:0]             data_sum;
  logic                        compact;

  logic                        out_valid_q;
  logic                        out_ign_q, out_bad_q, out_new_q, out_compact_q;
  logic [tecs_pkg::CountW-1:0] out_puts_q, out_dels_q, out_sdels_q, out_mo_q;
  logic [tecs_pkg::SizeW-1:0]  out_data_q, out_disk_q;
  logic [tecs_pkg::WinW-1:0]   out_wcnt_q, out_wmax_q;

  tecs_cfg_regs u_cfg (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_i),
    .cfg_o (cfg)
  );

  assign s1_go         = s1_valid_q && (!out_valid_q || result_o.ready);
  assign entry_i.ready = !busy && (!s1_valid_q || s1_go);
  assign acc           = entry_i.valid && entry_i.ready;

  assign ign    = (entry_i.key_len < tecs_pkg::MinKeyLen);
  assign fresh  = !ign && (!run_open_q || (entry_i.key_index != cur_idx_q));
  assign is_del = (entry_i.entry_type == tecs_pkg::EtDelete) ||
                  ((entry_i.entry_type == tecs_pkg::EtSingleDelete) &&
                   cfg.count_single_deletes);
  assign bad    = !ign && (entry_i.entry_type > tecs_pkg::EtOther);

  assign win_ctl.acc    = acc;
  assign win_ctl.en     = !ign;
  assign win_ctl.is_del = is_del;
  assign win_ctl.go     = s1_go;

  tecs_window #(
    .WindowDepth(WindowDepth)
  ) u_window (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .ctl_i (win_ctl),
    .busy_o(busy),
    .stat_o(win_stat)
  );

  always_comb begin
    puts_b   = s1_fresh_q ? '0 : puts_q;
    dels_b   = s1_fresh_q ? '0 : dels_q;
    sdels_b  = s1_fresh_q ? '0 : sdels_q;
    mo_b     = s1_fresh_q ? '0 : mo_q;
    data_b   = s1_fresh_q ? '0 : data_q;
    disk_b   = s1_fresh_q ? '0 : disk_q;
    data_sum = AddW'(data_b) + AddW'(s1_dsum_q);

    puts_d  = puts_q;
    dels_d  = dels_q;
    sdels_d = sdels_q;
    mo_d    = mo_q;
    data_d  = data_q;
    disk_d  = disk_q;
    if (s1_go && !s1_ign_q) begin
      puts_d  = puts_b;
      dels_d  = dels_b;
      sdels_d = sdels_b;
      mo_d    = mo_b;
      data_d  = data_sum[AddW-1] ? '1 : data_sum[tecs_pkg::SizeW-1:0];
      disk_d  = disk_b + s1_diff_q;
      unique case (s1_type_q)
        tecs_pkg::EtPut:          puts_d  = sat_cnt(puts_b);
        tecs_pkg::EtDelete:       dels_d  = sat_cnt(dels_b);
        tecs_pkg::EtSingleDelete: sdels_d = sat_cnt(sdels_b);
        tecs_pkg::EtMerge: begin
          mo_d[tecs_pkg::HalfW-1:0] = sat_half(mo_b[tecs_pkg::HalfW-1:0]);
        end
        tecs_pkg::EtOther: begin
          mo_d[tecs_pkg::CountW-1:tecs_pkg::HalfW] =
            sat_half(mo_b[tecs_pkg::CountW-1:tecs_pkg::HalfW]);
        end
        default: begin
          mo_d = mo_b;
        end
      endcase
    end
  end

  assign compact = (cfg.delete_threshold != '0) && (cfg.window_len != '0) &&
                   (last_fs_q > cfg.file_size_threshold) &&
                   (win_stat.max > cfg.delete_threshold);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q  <= 1'b0;
      cur_idx_q   <= '0;
      last_fs_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      puts_q      <= '0;
      dels_q      <= '0;
      sdels_q     <= '0;
      mo_q        <= '0;
      data_q      <= '0;
      disk_q      <= '0;
    end else begin
      if (acc && !ign) begin
        run_open_q <= 1'b1;
        cur_idx_q  <= entry_i.key_index;
        last_fs_q  <= entry_i.file_bytes;
      end
      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      puts_q  <= puts_d;
      dels_q  <= dels_d;
      sdels_q <= sdels_d;
      mo_q    <= mo_d;
      data_q  <= data_d;
      disk_q  <= disk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_ign_q   <= ign;
      s1_bad_q   <= bad;
      s1_fresh_q <= fresh;
      s1_type_q  <= entry_i.entry_type;
      s1_dsum_q  <= DsumW'(entry_i.key_len) + DsumW'(entry_i.value_len);
      s1_diff_q  <= entry_i.file_bytes - last_fs_q;
    end
    if (s1_go) begin
      out_ign_q     <= s1_ign_q;
      out_bad_q     <= s1_bad_q;
      out_new_q     <= s1_fresh_q;
      out_puts_q    <= puts_d;
      out_dels_q    <= dels_d;
      out_sdels_q   <= sdels_d;
      out_mo_q      <= mo_d;
      out_data_q    <= data_d;
      out_disk_q    <= disk_d;
      out_wcnt_q    <= win_stat.count;
      out_wmax_q    <= win_stat.max;
      out_compact_q <= compact;
    end
  end

  assign result_o.valid                 = out_valid_q;
  assign result_o.ignored               = out_ign_q;
  assign result_o.bad_type              = out_bad_q;
  assign result_o.new_run               = out_new_q;
  assign result_o.run_puts              = out_puts_q;
  assign result_o.run_deletes           = out_dels_q;
  assign result_o.run_single_deletes    = out_sdels_q;
  assign result_o.run_merges_and_others = out_mo_q;
  assign result_o.run_data_bytes        = out_data_q;
  assign result_o.run_disk_bytes        = out_disk_q;
  assign result_o.window_deletes        = out_wcnt_q;
  assign result_o.max_window_deletes    = out_wmax_q;
  assign result_o.need_compact          = out_compact_q;

endmodule

// File: rtl/tecs_checker.sv
// ----------------------------------------------------------------------------
// tecs_checker
// Port-level checks of the collector, bound to the top level.
// ----------------------------------------------------------------------------
module tecs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        ignored,
  input logic                        bad_type,
  input logic                        new_run,
  input logic [tecs_pkg::WinW-1:0]   window_deletes,
  input logic [tecs_pkg::WinW-1:0]   max_window_deletes,
  input logic                        need_compact
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(max_window_deletes))
    else $error("Stalled result was dropped or changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && ignored |-> !bad_type && !new_run)
    else $error("Ignored entry reported a type error or a new run.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> max_window_deletes >= window_deletes)
    else $error("Window delete count exceeds its maximum.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && need_compact |-> max_window_deletes != '0)
    else $error("Compaction requested without any window deletes.");

endmodule

bind table_entry_stats_collector tecs_checker u_tecs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid         (result_o.valid),
  .out_ready         (result_o.ready),
  .ignored           (result_o.ignored),
  .bad_type          (result_o.bad_type),
  .new_run           (result_o.new_run),
  .window_deletes    (result_o.window_deletes),
  .max_window_deletes(result_o.max_window_deletes),
  .need_compact      (result_o.need_compact)
);

// File: bench/tecs_stats_tracker_pkg.sv
// ----------------------------------------------------------------------------
// tecs_stats_tracker_pkg
// Expected-result tracking for the table entry statistics collector: keeps
// its own copy of the delete window, the run counters and the registers,
// works out the result of every accepted entry and compares each result
// transfer against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
package tecs_stats_tracker_pkg;

  import tecs_pkg::*;

  typedef struct packed {
    logic [IdW-1:0]   key_index;
    logic [KeyW-1:0]  key_len;
    logic [ValW-1:0]  value_len;
    logic [TypeW-1:0] entry_type;
    logic [SizeW-1:0] file_bytes;
  } entry_t;

  typedef struct packed {
    logic              ignored;
    logic              bad_type;
    logic              new_run;
    logic [CountW-1:0] run_puts;
    logic [CountW-1:0] run_deletes;
    logic [CountW-1:0] run_single_deletes;
    logic [CountW-1:0] run_merges_and_others;
    logic [SizeW-1:0]  run_data_bytes;
    logic [SizeW-1:0]  run_disk_bytes;
    logic [WinW-1:0]   window_deletes;
    logic [WinW-1:0]   max_window_deletes;
    logic              need_compact;
  } result_t;

  class tecs_stats_tracker;
    bit               delete_flags[WindowDepth];
    int unsigned      win_pos;
    int unsigned      win_count;
    int unsigned      win_max;
    bit [SizeW-1:0]   last_size;
    bit [IdW-1:0]     cur_index;
    bit               run_open;
    bit [CountW-1:0]  type_cnt[4];
    bit [SizeW-1:0]   data_bytes;
    bit [SizeW-1:0]   disk_bytes;
    bit [WinW-1:0]    window_len;
    bit [WinW-1:0]    delete_threshold;
    bit [SizeW-1:0]   size_threshold;
    bit               count_single;
    result_t          due_results[$];
    int unsigned      mismatches;

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        CfgWindowLen:          window_len = value[WinW-1:0];
        CfgDeleteThreshold:    delete_threshold = value[WinW-1:0];
        CfgFileSizeThreshold:  size_threshold = value[SizeW-1:0];
        CfgCountSingleDeletes: count_single = value[0];
        default: ;
      endcase
    endfunction

    function void shift_window(bit is_del);
      int unsigned span;
      if (window_len == 0) return;
      span = (window_len > WindowDepth) ? WindowDepth : window_len;
      if (win_pos >= span) win_pos = 0;
      if (delete_flags[win_pos] != is_del) begin
        delete_flags[win_pos] = is_del;
        if (is_del) begin
          win_count++;
          if (win_count > win_max) win_max = win_count;
        end else begin
          win_count--;
        end
      end
      win_pos++;
      if (win_pos >= span) win_pos = 0;
    endfunction

    function void take_entry(entry_t e);
      result_t        r;
      bit             is_del;
      bit [SizeW:0]   sum;
      bit [HalfW-1:0] half;
      r = '0;
      if (e.key_len < MinKeyLen) begin
        r.ignored = 1'b1;
      end else begin
        is_del = (e.entry_type == EtDelete) ||
                 (e.entry_type == EtSingleDelete && count_single);
        shift_window(is_del);
        if (!run_open || e.key_index != cur_index) begin
          run_open = 1'b1;
          cur_index = e.key_index;
          foreach (type_cnt[i]) type_cnt[i] = '0;
          data_bytes = '0;
          disk_bytes = '0;
          r.new_run = 1'b1;
        end
        sum = {1'b0, data_bytes} + e.key_len + e.value_len;
        data_bytes = sum[SizeW] ? '1 : sum[SizeW-1:0];
        case (e.entry_type)
          EtPut, EtDelete, EtSingleDelete: begin
            if (type_cnt[e.entry_type] != '1) type_cnt[e.entry_type]++;
          end
          EtMerge: begin
            half = type_cnt[3][HalfW-1:0];
            if (half != '1) type_cnt[3][HalfW-1:0] = half + 1'b1;
          end
          EtOther: begin
            half = type_cnt[3][2*HalfW-1:HalfW];
            if (half != '1) type_cnt[3][2*HalfW-1:HalfW] = half + 1'b1;
          end
          default: r.bad_type = 1'b1;
        endcase
        disk_bytes = disk_bytes + (e.file_bytes - last_size);
        last_size = e.file_bytes;
      end
      r.run_puts = type_cnt[0];
      r.run_deletes = type_cnt[1];
      r.run_single_deletes = type_cnt[2];
      r.run_merges_and_others = type_cnt[3];
      r.run_data_bytes = data_bytes;
      r.run_disk_bytes = disk_bytes;
      r.window_deletes = WinW'(win_count);
      r.max_window_deletes = WinW'(win_max);
      r.need_compact = delete_threshold != 0 && window_len != 0 &&
                       last_size > size_threshold && win_max > delete_threshold;
      due_results.insert(due_results.size(), r);
    endfunction

    function void compare_field(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("%s: expected %0h, got %0h", what, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result transfer with nothing outstanding");
        return;
      end
      want = due_results.pop_front();
      compare_field("ignored", want.ignored, got.ignored);
      compare_field("bad_type", want.bad_type, got.bad_type);
      compare_field("new_run", want.new_run, got.new_run);
      compare_field("run_puts", want.run_puts, got.run_puts);
      compare_field("run_deletes", want.run_deletes, got.run_deletes);
      compare_field("run_single_deletes", want.run_single_deletes, got.run_single_deletes);
      compare_field("run_merges_and_others", want.run_merges_and_others,
                    got.run_merges_and_others);
      compare_field("run_data_bytes", want.run_data_bytes, got.run_data_bytes);
      compare_field("run_disk_bytes", want.run_disk_bytes, got.run_disk_bytes);
      compare_field("window_deletes", want.window_deletes, got.window_deletes);
      compare_field("max_window_deletes", want.max_window_deletes, got.max_window_deletes);
      compare_field("need_compact", want.need_compact, got.need_compact);
    endfunction
  endclass

endpackage

// File: bench/table_entry_stats_collector_test.sv
// ----------------------------------------------------------------------------
// table_entry_stats_collector_test
// Drives entries through the collector under several register settings, with
// a directed opening and random streams of index runs, deletes and file
// sizes, while both channels idle and stall at random. Every result transfer
// is checked field by field against the tracker's expectation.
// ----------------------------------------------------------------------------
module table_entry_stats_collector_test;

  import tecs_pkg::*;
  import tecs_stats_tracker_pkg::*;

  localparam int unsigned IdleLimit     = 20000;
  localparam int unsigned HoldoffCycles = 300;
  localparam int unsigned PhaseItems    = 56;

  localparam logic [TypeW-1:0]   EtBadFirst   = TypeW'(5);
  localparam logic [TypeW-1:0]   EtBadMid     = TypeW'(6);
  localparam logic [TypeW-1:0]   EtBadLast    = TypeW'(7);
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] CfgTopIdx    = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tecs_cfg_if    cfg_bus();
  tecs_entry_if  entry_bus();
  tecs_result_if result_bus();

  table_entry_stats_collector DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .entry_i  (entry_bus),
    .result_o (result_bus)
  );

  tecs_stats_tracker tracker = new();

  int unsigned    burst_left = 0;
  bit             holdoff_req = 1'b0;
  bit [SizeW-1:0] size_now = '0;
  bit [IdW-1:0]   id_now = '0;
  bit [IdW-1:0]   id_pool[4];
  entry_t         accepted_entry;
  result_t        seen_result;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && cfg_bus.valid && cfg_bus.ready) begin
      tracker.write_reg(cfg_bus.index, cfg_bus.data);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && entry_bus.valid && entry_bus.ready) begin
      accepted_entry.key_index = entry_bus.key_index;
      accepted_entry.key_len = entry_bus.key_len;
      accepted_entry.value_len = entry_bus.value_len;
      accepted_entry.entry_type = entry_bus.entry_type;
      accepted_entry.file_bytes = entry_bus.file_bytes;
      tracker.take_entry(accepted_entry);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      seen_result.ignored = result_bus.ignored;
      seen_result.bad_type = result_bus.bad_type;
      seen_result.new_run = result_bus.new_run;
      seen_result.run_puts = result_bus.run_puts;
      seen_result.run_deletes = result_bus.run_deletes;
      seen_result.run_single_deletes = result_bus.run_single_deletes;
      seen_result.run_merges_and_others = result_bus.run_merges_and_others;
      seen_result.run_data_bytes = result_bus.run_data_bytes;
      seen_result.run_disk_bytes = result_bus.run_disk_bytes;
      seen_result.window_deletes = result_bus.window_deletes;
      seen_result.max_window_deletes = result_bus.max_window_deletes;
      seen_result.need_compact = result_bus.need_compact;
      tracker.check_result(seen_result);
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((cfg_bus.valid && cfg_bus.ready) || (entry_bus.valid && entry_bus.ready) ||
          (result_bus.valid && result_bus.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : result_sink
    int unsigned seg;
    int unsigned mode;
    int unsigned step;
    bit [7:0]    stall_pattern;
    result_bus.ready = 1'b0;
    step = 0;
    forever begin
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        repeat (HoldoffCycles) begin
          @(negedge clk_i);
          result_bus.ready = 1'b0;
        end
      end else begin
        mode = $urandom_range(2, 0);
        seg = $urandom_range(40, 1);
        stall_pattern = 8'($urandom());
        repeat (seg) begin
          @(negedge clk_i);
          case (mode)
            0: result_bus.ready = 1'b1;
            1: result_bus.ready = ($urandom_range(3, 0) != 0);
            default: result_bus.ready = stall_pattern[step[2:0]];
          endcase
          step++;
        end
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic configure(logic [WinW-1:0] wlen, logic [WinW-1:0] thr,
                           logic [SizeW-1:0] size_thr, bit single_del);
    write_reg(CfgWindowLen, CfgDataW'(wlen));
    write_reg(CfgDeleteThreshold, CfgDataW'(thr));
    write_reg(CfgFileSizeThreshold, CfgDataW'(size_thr));
    write_reg(CfgCountSingleDeletes, CfgDataW'(single_del));
  endtask

  task automatic drain();
    @(negedge clk_i);
    entry_bus.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_entry(entry_t e);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6, 0);
      burst_left = ($urandom_range(5, 0) == 0) ? 60 : $urandom_range(16, 1);
      if (gap > 0) begin
        @(negedge clk_i);
        entry_bus.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    entry_bus.valid = 1'b1;
    entry_bus.key_index = e.key_index;
    entry_bus.key_len = e.key_len;
    entry_bus.value_len = e.value_len;
    entry_bus.entry_type = e.entry_type;
    entry_bus.file_bytes = e.file_bytes;
    do @(posedge clk_i); while (!entry_bus.ready);
    burst_left--;
  endtask

  task automatic offer(logic [IdW-1:0] id, logic [KeyW-1:0] klen, logic [ValW-1:0] vlen,
                       logic [TypeW-1:0] kind, logic [SizeW-1:0] size);
    entry_t e;
    e.key_index = id;
    e.key_len = klen;
    e.value_len = vlen;
    e.entry_type = kind;
    e.file_bytes = size;
    send_entry(e);
  endtask

  function automatic logic [SizeW-1:0] rand_size();
    return SizeW'({$urandom(), $urandom()});
  endfunction

  function automatic entry_t random_entry();
    entry_t      e;
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 10) id_now = id_pool[$urandom_range(3, 0)];
    else if (roll < 13) id_now = $urandom();
    e.key_index = id_now;
    roll = $urandom_range(19, 0);
    if (roll < 2) e.key_len = KeyW'($urandom_range(3, 0));
    else if (roll < 4) e.key_len = KeyW'($urandom());
    else e.key_len = KeyW'($urandom_range(64, 4));
    e.value_len = ($urandom_range(7, 0) == 0) ? ValW'($urandom()) :
                                                ValW'($urandom_range(200, 0));
    roll = $urandom_range(99, 0);
    if (roll < 30) e.entry_type = EtPut;
    else if (roll < 60) e.entry_type = EtDelete;
    else if (roll < 75) e.entry_type = EtSingleDelete;
    else if (roll < 85) e.entry_type = EtMerge;
    else if (roll < 93) e.entry_type = EtOther;
    else e.entry_type = TypeW'($urandom_range(EtBadLast, EtBadFirst));
    roll = $urandom_range(19, 0);
    if (roll == 0) size_now = rand_size();
    else if (roll == 1) size_now = size_now - SizeW'($urandom_range(5000, 1));
    else size_now = size_now + SizeW'($urandom_range(300, 0));
    e.file_bytes = size_now;
    return e;
  endfunction

  task automatic random_phase();
    entry_t      e;
    int unsigned counted;
    counted = 0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    id_pool[2] = $urandom();
    id_pool[3] = $urandom();
    while (counted < PhaseItems) begin
      e = random_entry();
      send_entry(e);
      if (e.key_len >= MinKeyLen) counted++;
    end
  endtask

  initial begin : stimulus
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    entry_bus.valid = 1'b0;
    entry_bus.key_index = '0;
    entry_bus.key_len = '0;
    entry_bus.value_len = '0;
    entry_bus.entry_type = '0;
    entry_bus.file_bytes = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    configure(WinW'(8), WinW'(2), SizeW'(100), 1'b1);
    write_reg(CfgUnusedIdx, CfgDataW'(3));
    write_reg(CfgTopIdx, '1);
    offer('0, KeyW'(0), ValW'(7), EtPut, SizeW'(50));
    offer('0, KeyW'(3), ValW'(7), EtDelete, SizeW'(500));
    offer('0, KeyW'(4), ValW'(0), EtPut, SizeW'(10));
    offer('0, KeyW'(4), ValW'(20), EtDelete, SizeW'(200));
    offer('0, KeyW'(16), ValW'(3), EtSingleDelete, SizeW'(300));
    offer('0, KeyW'(8), ValW'(9), EtMerge, SizeW'(310));
    offer('0, KeyW'(8), ValW'(9), EtOther, SizeW'(320));
    offer('0, KeyW'(5), ValW'(1), EtBadFirst, SizeW'(330));
    offer('0, KeyW'(5), ValW'(1), EtBadMid, SizeW'(340));
    offer('0, KeyW'(5), ValW'(1), EtBadLast, SizeW'(350));
    offer('0, KeyW'(6), ValW'(2), EtDelete, SizeW'(360));
    offer('1, '1, '1, EtPut, '1);
    offer('1, KeyW'(4), ValW'(0), EtDelete, '0);
    offer(IdW'(32'h1234_5678), KeyW'(2), ValW'(5), EtMerge, SizeW'(77));
    offer(IdW'(32'h1234_5678), KeyW'(12), ValW'(5), EtMerge, SizeW'(400));
    repeat (8) offer(IdW'(32'h1234_5678), KeyW'(12), ValW'(5), EtPut, SizeW'(450));
    offer(IdW'(32'hA5A5_5A5A), KeyW'(4), '1, EtSingleDelete, SizeW'(460));
    size_now = SizeW'(460);
    drain();

    configure(WinW'(16), WinW'(3), '0, 1'b0);
    random_phase();
    drain();
    configure(WinW'(3), WinW'(1), SizeW'($urandom()), 1'b1);
    random_phase();
    drain();
    configure(WinW'(WindowDepth), WinW'(WindowDepth), '1, 1'b1);
    @(posedge clk_i);
    holdoff_req = 1'b1;
    random_phase();
    drain();
    configure('0, '0, '0, 1'b0);
    random_phase();
    drain();
    configure(WinW'(1), WinW'($urandom_range(8, 1)), '0, 1'($urandom()));
    random_phase();
    drain();
    configure(WinW'($urandom_range(64, 1)), WinW'($urandom_range(10, 0)),
              SizeW'($urandom_range(1000, 0)), 1'($urandom()));
    @(posedge clk_i);
    holdoff_req = 1'b1;
    random_phase();

    @(negedge clk_i);
    entry_bus.valid = 1'b0;
    drain();
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tecs_pkg.sv
rtl/tecs_if.sv
rtl/tecs_ram.sv
rtl/tecs_cfg_regs.sv
rtl/tecs_window.sv
rtl/table_entry_stats_collector.sv
rtl/tecs_checker.sv
bench/tecs_stats_tracker_pkg.sv
bench/table_entry_stats_collector_test.sv
